// File: hw/rtl/cdc_pkg.sv
// Package for the Gregorian calendar date counter.
// Holds the item types, opcode, status and sequencer codes, and the calendar functions.
// No dependencies.
`default_nettype none

package cdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned CountW = 16;

  localparam logic [YearW-1:0]  LoadYearMin = 12'd1800;
  localparam logic [YearW-1:0]  LoadYearMax = 12'd2100;
  localparam logic [YearW-1:0]  HeldYearMin = 12'd1;
  localparam logic [YearW-1:0]  HeldYearMax = 12'd4095;
  localparam logic [YearW-1:0]  ResetYear   = 12'd2000;
  localparam logic [CountW-1:0] MaxStepDays = 16'd65535;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_NEXT_DAY = 3'd1,
    OP_PREV_DAY = 3'd2,
    OP_ADD_DAYS = 3'd3,
    OP_SUB_DAYS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LOAD = 2'd1,
    STAT_LIMIT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [DayW-1:0]   load_day;
    logic [MonthW-1:0] load_month;
    logic [YearW-1:0]  load_year;
    logic [CountW-1:0] day_count;
  } in_item_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // True when a 10-bit value is a multiple of 25. The quotient comes from a
  // reciprocal multiply, which is exact over this range.
  function automatic logic is_mult25(input logic [9:0] v);
    logic [20:0] prod;
    logic [5:0]  quo;
    logic [10:0] back;
    prod = {11'd0, v} * 21'd1311;
    quo  = prod[20:15];
    back = {5'd0, quo} * 11'd25;
    return back == {1'b0, v};
  endfunction

  // Leap year by the 4/100/400 rule. With y a multiple of 4, y/4 being a
  // multiple of 25 means a century year, which leaps only when y/16 is whole.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [9:0] quarter;
    quarter = y[YearW-1:2];
    if (y[1:0] != 2'd0) begin
      return 1'b0;
    end
    if (!is_mult25(quarter)) begin
      return 1'b1;
    end
    return quarter[1:0] == 2'd0;
  endfunction

  // Days in a month; codes outside 1 to 12 give 31.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic [YearW-1:0] y);
    logic [DayW-1:0] len;
    case (m) inside
      4'd2: begin
        len = is_leap(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cdc_step_unit.sv
// Shared one-day step unit: moves a date one day forward or back.
// Depends on cdc_pkg for the date type and the month length function.
`default_nettype none

module cdc_step_unit import cdc_pkg::*; (
  input  date_t cur,
  input  logic  fwd,
  output date_t nxt,
  output logic  moved
);

  logic [DayW-1:0]   cur_len;
  logic [MonthW-1:0] prev_month;
  logic [DayW-1:0]   prev_len;

  assign cur_len    = month_len(cur.month, cur.year);
  assign prev_month = cur.month - 4'd1;
  assign prev_len   = month_len(prev_month, cur.year);

  always_comb begin
    nxt   = cur;
    moved = 1'b1;
    if (fwd) begin
      if (cur.day < cur_len) begin
        nxt.day = cur.day + 5'd1;
      end else if (cur.month < 4'd12) begin
        nxt.month = cur.month + 4'd1;
        nxt.day   = 5'd1;
      end else if (cur.year < HeldYearMax) begin
        nxt.year  = cur.year + 12'd1;
        nxt.month = 4'd1;
        nxt.day   = 5'd1;
      end else begin
        moved = 1'b0;
      end
    end else begin
      if (cur.day > 5'd1) begin
        nxt.day = cur.day - 5'd1;
      end else if (cur.month > 4'd1) begin
        nxt.month = prev_month;
        nxt.day   = prev_len;
      end else if (cur.year > HeldYearMin) begin
        nxt.year  = cur.year - 12'd1;
        nxt.month = 4'd12;
        nxt.day   = 5'd31;
      end else begin
        moved = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/calendar_date_up_down_counter_core.sv
// Gregorian date counter, reset to 1/1/2000. An item is taken only while idle;
// load and unused opcodes go from the accept straight to showing the result,
// a one-day step runs a single step first, and an add or subtract of N days runs N steps
// (none for zero days), since the shared step unit moves the date one day per cycle.
// The result stays shown for as long as out_ready stays low.
// A step that would cross 31/12/4095 or 1/1/1 ends the item early with the limit status.
`default_nettype none

module calendar_date_up_down_counter_core import cdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  seq_state_t        state_r, state_nxt;
  date_t             date_r, date_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              fwd_r, fwd_nxt;
  status_t           status_r, status_nxt;

  date_t step_date;
  logic  step_moved;
  logic  load_ok;
  logic  [CountW-1:0] req_count;

  cdc_step_unit u_step (
    .cur   (date_r),
    .fwd   (fwd_r),
    .nxt   (step_date),
    .moved (step_moved)
  );

  assign load_ok = (in_item.load_day != 5'd0) &&
                   (in_item.load_month >= 4'd1) && (in_item.load_month <= 4'd12) &&
                   (in_item.load_year >= LoadYearMin) &&
                   (in_item.load_year <= LoadYearMax) &&
                   (in_item.load_day <= month_len(in_item.load_month, in_item.load_year));

  // The count field is no wider than the step limit, so the clamp only bites
  // if the limit is lowered.
  assign req_count = (in_item.day_count > MaxStepDays) ? MaxStepDays : in_item.day_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      date_r   <= '{day: 5'd1, month: 4'd1, year: ResetYear};
      status_r <= STAT_OK;
      count_r  <= '0;
      fwd_r    <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      date_r   <= date_nxt;
      status_r <= status_nxt;
      count_r  <= count_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    date_nxt   = date_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    fwd_nxt    = fwd_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = STAT_OK;
          state_nxt  = SEQ_DONE;
          case (in_item.opcode)
            OP_LOAD: begin
              if (load_ok) begin
                date_nxt = '{day: in_item.load_day, month: in_item.load_month,
                             year: in_item.load_year};
              end else begin
                status_nxt = STAT_BAD_LOAD;
              end
            end
            OP_NEXT_DAY, OP_PREV_DAY: begin
              count_nxt = 16'd1;
              fwd_nxt   = (in_item.opcode == OP_NEXT_DAY);
              state_nxt = SEQ_RUN;
            end
            OP_ADD_DAYS, OP_SUB_DAYS: begin
              count_nxt = req_count;
              fwd_nxt   = (in_item.opcode == OP_ADD_DAYS);
              if (req_count != '0) begin
                state_nxt = SEQ_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_RUN: begin
        if (step_moved) begin
          date_nxt  = step_date;
          count_nxt = count_r - 16'd1;
          if (count_r == 16'd1) begin
            state_nxt = SEQ_DONE;
          end
        end else begin
          // Year limit reached: the remaining days are dropped.
          status_nxt = STAT_LIMIT;
          state_nxt  = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // The date and status registers hold still while the result waits.
  assign out_item = '{day: date_r.day, month: date_r.month, year: date_r.year,
                      status: status_r};

endmodule

`default_nettype wire

// File: test/tb_calendar_date_up_down_counter_core.sv
// Self-checking testbench for the calendar date counter core.
// Drives date commands through the item handshake and checks each result against a
// behavioral date predictor or a directed result; depends only on cdc_pkg and the core.
module tb_calendar_date_up_down_counter_core;
  import cdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 10_000_000;
  localparam int unsigned RandomItems = 55;
  localparam int unsigned HoldAt      = 90;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [2:0]  OpSpareLo   = 3'd5;
  localparam logic [2:0]  OpSpareHi   = 3'd7;

  typedef struct {
    in_item_t    cmd;
    int unsigned reps;
    bit          typed;
    out_item_t   res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Predicted calendar state.
  int unsigned cal_day;
  int unsigned cal_month;
  int unsigned cal_year;

  out_item_t   due_dates[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  calendar_date_up_down_counter_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Moves the predicted date one day; returns 0 when the held year range blocks it.
  function automatic bit step_date(input bit fwd);
    if (fwd) begin
      if (cal_day < days_in_month(cal_month, cal_year)) begin
        cal_day++;
      end else if (cal_month < 12) begin
        cal_month++;
        cal_day = 1;
      end else if (cal_year < HeldYearMax) begin
        cal_year++;
        cal_month = 1;
        cal_day = 1;
      end else begin
        return 1'b0;
      end
    end else begin
      if (cal_day > 1) begin
        cal_day--;
      end else if (cal_month > 1) begin
        cal_month--;
        cal_day = days_in_month(cal_month, cal_year);
      end else if (cal_year > HeldYearMin) begin
        cal_year--;
        cal_month = 12;
        cal_day = 31;
      end else begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic out_item_t advance_calendar(input in_item_t c);
    out_item_t   r;
    status_t     st;
    int unsigned n;
    int unsigned k;
    bit          fwd;
    st  = STAT_OK;
    n   = 0;
    fwd = 1'b1;
    case (c.opcode)
      OP_LOAD: begin
        if (c.load_day == 0 || c.load_month < 1 || c.load_month > 12 ||
            c.load_year < LoadYearMin || c.load_year > LoadYearMax ||
            c.load_day > days_in_month(c.load_month, c.load_year)) begin
          st = STAT_BAD_LOAD;
        end else begin
          cal_day   = c.load_day;
          cal_month = c.load_month;
          cal_year  = c.load_year;
        end
      end
      OP_NEXT_DAY: begin
        n = 1;
      end
      OP_PREV_DAY: begin
        n   = 1;
        fwd = 1'b0;
      end
      OP_ADD_DAYS: begin
        n = c.day_count;
      end
      OP_SUB_DAYS: begin
        n   = c.day_count;
        fwd = 1'b0;
      end
      default: begin
      end
    endcase
    if (n > MaxStepDays) begin
      n = MaxStepDays;
    end
    for (k = 0; k < n && st == STAT_OK; k++) begin
      if (!step_date(fwd)) begin
        st = STAT_LIMIT;
      end
    end
    r.day    = cal_day[DayW-1:0];
    r.month  = cal_month[MonthW-1:0];
    r.year   = cal_year[YearW-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic in_item_t date_cmd(input logic [2:0] op, input int unsigned d,
                                        input int unsigned m, input int unsigned y,
                                        input int unsigned cnt);
    in_item_t c;
    c.opcode     = op;
    c.load_day   = d[DayW-1:0];
    c.load_month = m[MonthW-1:0];
    c.load_year  = y[YearW-1:0];
    c.day_count  = cnt[CountW-1:0];
    return c;
  endfunction

  function automatic out_item_t date_res(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input status_t st);
    out_item_t r;
    r.day    = d[DayW-1:0];
    r.month  = m[MonthW-1:0];
    r.year   = y[YearW-1:0];
    r.status = st;
    return r;
  endfunction

  task automatic add_row(input in_item_t c, input int unsigned reps, input bit typed,
                         input out_item_t res);
    dir_row_t row;
    row.cmd   = c;
    row.reps  = reps;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Offers one item, after a random gap unless no_gap is set, and records what it should produce once taken.
  task automatic send_item(input in_item_t c, input bit typed, input out_item_t res,
                           input bit no_gap);
    int unsigned gap;
    out_item_t   pred;
    @(negedge clk);
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = advance_calendar(c);
    due_dates.push_back(typed ? res : pred);
  endtask

  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    out_ready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken == HoldAt) begin
        gap = HoldCycles;
      end else if (taken >= 60 && taken < 75) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_dates.size() == 0) begin
        $error("unexpected result %0d/%0d/%0d status %0d",
               out_item.day, out_item.month, out_item.year, out_item.status);
        mismatches++;
      end else begin
        want = due_dates.pop_front();
        if (out_item.day !== want.day) begin
          $error("day: expected %0d, got %0d", want.day, out_item.day);
          mismatches++;
        end
        if (out_item.month !== want.month) begin
          $error("month: expected %0d, got %0d", want.month, out_item.month);
          mismatches++;
        end
        if (out_item.year !== want.year) begin
          $error("year: expected %0d, got %0d", want.year, out_item.year);
          mismatches++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_calendar_date_up_down_counter_core: errors");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    in_item_t    cmd;
    int unsigned pick;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cal_day   = 1;
    cal_month = 1;
    cal_year  = ResetYear;

    // Spare opcodes right after reset and after a step forward and back show the reset date.
    add_row(date_cmd(OpSpareLo, 0, 0, 0, 0), 1, 1'b1, date_res(1, 1, 2000, STAT_OK));
    add_row(date_cmd(OP_NEXT_DAY, 0, 0, 0, 0), 1, 1'b0, '0);
    add_row(date_cmd(OP_PREV_DAY, 0, 0, 0, 0), 1, 1'b0, '0);
    add_row(date_cmd(OpSpareHi, 31, 15, 4095, 65535), 1, 1'b1,
            date_res(1, 1, 2000, STAT_OK));
    add_row(date_cmd(OP_LOAD, 29, 2, 2000, 0), 1, 1'b1, date_res(29, 2, 2000, STAT_OK));
    // Rejected loads leave the leap day in place.
    add_row(date_cmd(OP_LOAD, 29, 2, 1900, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 0, 1, 2000, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 1, 0, 0, 0), 1, 1'b1, date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 1, 13, 2000, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 31, 12, 1799, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 1, 1, 2101, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 31, 4, 2001, 0), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_LOAD, 31, 15, 4095, 65535), 1, 1'b1,
            date_res(29, 2, 2000, STAT_BAD_LOAD));
    add_row(date_cmd(OP_ADD_DAYS, 0, 0, 0, 1), 1, 1'b0, '0);
    add_row(date_cmd(OP_LOAD, 31, 12, 2100, 0), 1, 1'b1, date_res(31, 12, 2100, STAT_OK));
    add_row(date_cmd(OP_ADD_DAYS, 0, 0, 0, 0), 1, 1'b1, date_res(31, 12, 2100, STAT_OK));
    add_row(date_cmd(OP_NEXT_DAY, 0, 0, 0, 0), 1, 1'b0, '0);
    add_row(date_cmd(OP_LOAD, 1, 1, 1800, 0), 1, 1'b1, date_res(1, 1, 1800, STAT_OK));
    add_row(date_cmd(OP_SUB_DAYS, 0, 0, 0, 0), 1, 1'b1, date_res(1, 1, 1800, STAT_OK));
    // Walk down to the first day of year 1 and into the lower limit.
    add_row(date_cmd(OP_SUB_DAYS, 0, 0, 0, 65535), 10, 1'b0, '0);
    add_row(date_cmd(OP_SUB_DAYS, 0, 0, 0, 65535), 1, 1'b1, date_res(1, 1, 1, STAT_LIMIT));
    add_row(date_cmd(OP_PREV_DAY, 0, 0, 0, 0), 1, 1'b1, date_res(1, 1, 1, STAT_LIMIT));
    // Walk up to the last day of year 4095 and into the upper limit.
    add_row(date_cmd(OP_LOAD, 31, 12, 2100, 0), 1, 1'b1, date_res(31, 12, 2100, STAT_OK));
    add_row(date_cmd(OP_ADD_DAYS, 0, 0, 0, 65535), 11, 1'b0, '0);
    add_row(date_cmd(OP_ADD_DAYS, 0, 0, 0, 65535), 1, 1'b1,
            date_res(31, 12, 4095, STAT_LIMIT));
    add_row(date_cmd(OP_NEXT_DAY, 0, 0, 0, 0), 1, 1'b1, date_res(31, 12, 4095, STAT_LIMIT));
    add_row(date_cmd(OP_LOAD, 28, 2, 2024, 0), 1, 1'b1, date_res(28, 2, 2024, STAT_OK));
    add_row(date_cmd(OP_ADD_DAYS, 0, 0, 0, 2), 1, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (r = 1; r <= row.reps; r++) begin
        send_item(row.cmd, row.typed && r == row.reps, row.res, 1'b0);
      end
    end

    for (k = 0; k < RandomItems; k++) begin
      // Unused fields carry noise so every bit toggles.
      cmd.load_day   = DayW'($urandom);
      cmd.load_month = MonthW'($urandom);
      cmd.load_year  = YearW'($urandom);
      cmd.day_count  = CountW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        cmd.opcode = OP_LOAD;
        if (pick < 22) begin
          cmd.load_year  = YearW'($urandom_range(LoadYearMin, LoadYearMax));
          cmd.load_month = MonthW'($urandom_range(1, 12));
          len = days_in_month(cmd.load_month, cmd.load_year);
          cmd.load_day = (pick < 6) ? DayW'(len) : DayW'($urandom_range(1, len));
          // A day just past the end of the month.
          if (pick >= 19) begin
            cmd.load_day = DayW'(len + 1);
          end
        end
      end else if (pick < 40) begin
        cmd.opcode = OP_NEXT_DAY;
      end else if (pick < 55) begin
        cmd.opcode = OP_PREV_DAY;
      end else if (pick < 95) begin
        cmd.opcode = (pick < 75) ? OP_ADD_DAYS : OP_SUB_DAYS;
        if ($urandom_range(0, 29) != 0) begin
          cmd.day_count = CountW'($urandom_range(0, 400));
        end
      end else begin
        cmd.opcode = 3'($urandom_range(OpSpareLo, OpSpareHi));
      end
      if (k == 50) begin
        // The last item is already taken; stop offering it before the block goes idle.
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_dates.size() != 0) @(negedge clk);
      end
      send_item(cmd, 1'b0, '0, k >= 30 && k < 45);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_calendar_date_up_down_counter_core: clean");
    end else begin
      $display("tb_calendar_date_up_down_counter_core: errors");
    end
    $finish;
  end

endmodule
